>>> hw/rtl/wtf8_to_utf16_decoder_core_macros.svh
// assertion macros used by the decoder top level
`ifndef WTF8_TO_UTF16_DECODER_CORE_MACROS_SVH
`define WTF8_TO_UTF16_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define W2U_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define W2U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/w2u_pkg.sv
// shared types, constants and helpers of the wtf-8 to utf-16 decoder
`timescale 1ns / 1ps
package w2u_pkg;

  localparam logic [15:0] REPL_UNIT = 16'hFFFD;
  localparam logic [15:0] HIGH_BASE = 16'hD800;
  localparam logic [15:0] LOW_BASE  = 16'hDC00;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // window of held bytes plus the new one
  localparam int WIN_DEPTH = 4;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one decoded code point or one error, as handed to the back end
  typedef struct packed {
    logic        repl;   // decoding error, gives the replacement unit
    logic        pair;   // supplementary, val holds code point minus 0x10000
    logic        last;   // last command caused by this byte
    logic        fin;    // byte was the final one of the string
    logic [20:0] val;
  } cmd_t;

  // sequence length from a lead byte, zero for a bad lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (!b[7]) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

>>> hw/rtl/w2u_front.sv
// front end: takes bytes into the window and decodes one sequence per cycle while the queue has room
`timescale 1ns / 1ps
module w2u_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_final_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output w2u_pkg::cmd_t cmd_o
);
  import w2u_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e      state_q, state_d;
  logic [7:0]  win_q [WIN_DEPTH];
  logic [7:0]  win_sh [WIN_DEPTH];
  logic [2:0]  rem_q, rem_d;
  logic        fin_q, fin_d;

  logic [7:0]  b0;
  logic [2:0]  len;
  logic        bad_lead, short_seq, brk, cont_ok, good, pair;
  logic [20:0] cp;
  logic [2:0]  consume;
  logic [2:0]  new_rem;
  logic [2:0]  nlen;
  logic        last;
  logic        accept, step;

  assign b0        = win_q[0];
  assign len       = lead_len(b0);
  assign bad_lead  = (len == 3'd0);
  assign short_seq = !bad_lead && (len > rem_q);
  assign brk       = short_seq && !fin_q;

  always_comb begin
    cont_ok = 1'b1;
    for (int k = 1; k < WIN_DEPTH; k++) begin
      if ((3'(k) < len) && (win_q[k][7:6] != 2'b10)) begin
        cont_ok = 1'b0;
      end
    end
  end

  always_comb begin
    case (len)
      3'd1:    cp = {13'd0, b0};
      3'd2:    cp = {10'd0, b0[4:0], win_q[1][5:0]};
      3'd3:    cp = {5'd0, b0[3:0], win_q[1][5:0], win_q[2][5:0]};
      3'd4:    cp = {b0[2:0], win_q[1][5:0], win_q[2][5:0], win_q[3][5:0]};
      default: cp = 21'd0;
    endcase
  end

  assign good    = !bad_lead && !short_seq && cont_ok;
  assign pair    = good && (cp[20:16] != 5'd0);
  assign consume = good ? len : 3'd1;
  assign new_rem = rem_q - consume;

  always_comb begin
    logic [2:0] idx;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      idx = 3'(i) + consume;
      win_sh[i] = (idx < 3'(WIN_DEPTH)) ? win_q[idx[1:0]] : 8'h00;
    end
  end

  // stop after this command when nothing is left or the next lead must wait
  assign nlen = lead_len(win_sh[0]);
  assign last = (new_rem == 3'd0) ||
                ((nlen != 3'd0) && (nlen > new_rem) && !fin_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = (state_q == S_RUN) && !brk;
  assign step        = cmd_valid_o && cmd_ready_i;

  assign cmd_o.repl = !good;
  assign cmd_o.pair = pair;
  assign cmd_o.last = last;
  assign cmd_o.fin  = fin_q;
  assign cmd_o.val  = pair ? (cp - SUPP_BASE) : cp;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    fin_d   = fin_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rem_d   = rem_q + 3'd1;
          fin_d   = in_final_i;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (brk) begin
          state_d = S_IDLE;
        end else if (step) begin
          rem_d = new_rem;
          if (last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q   <= 3'd0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      fin_q   <= fin_d;
    end
  end

  // byte window, held bytes sit at the low end
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q[rem_q[1:0]] <= in_byte_i;
    end else if (step) begin
      win_q <= win_sh;
    end
  end

endmodule

>>> hw/rtl/w2u_cmd_fifo.sv
// small command queue between the decode front and the unit back end
`timescale 1ns / 1ps
module w2u_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  w2u_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output w2u_pkg::cmd_t pop_data_o
);
  import w2u_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/w2u_back.sv
// back end: turns commands into utf-16 units behind an output register
`timescale 1ns / 1ps
module w2u_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  w2u_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [15:0]   code_unit_o,
  output logic          is_replacement_o,
  output logic          run_last_o,
  output logic          string_end_o
);
  import w2u_pkg::*;

  logic        valid_q;
  logic        half_q;
  logic [15:0] unit_q;
  logic        repl_q, run_last_q, end_q;

  logic        load, final_unit;
  logic [15:0] unit_d;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    final_unit = 1'b1;
    if (cmd_i.repl) begin
      unit_d = REPL_UNIT;
    end else if (cmd_i.pair && !half_q) begin
      unit_d     = HIGH_BASE + {5'd0, cmd_i.val[20:10]};
      final_unit = 1'b0;
    end else if (cmd_i.pair) begin
      unit_d = LOW_BASE + {6'd0, cmd_i.val[9:0]};
    end else begin
      unit_d = cmd_i.val[15:0];
    end
  end

  assign cmd_ready_o = load && final_unit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else if (load) begin
      valid_q <= cmd_valid_i;
      if (cmd_valid_i) begin
        half_q <= !final_unit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && cmd_valid_i) begin
      unit_q     <= unit_d;
      repl_q     <= cmd_i.repl;
      run_last_q <= final_unit && cmd_i.last;
      end_q      <= final_unit && cmd_i.last && cmd_i.fin;
    end
  end

  assign out_valid_o      = valid_q;
  assign code_unit_o      = unit_q;
  assign is_replacement_o = repl_q;
  assign run_last_o       = run_last_q;
  assign string_end_o     = end_q;

endmodule

>>> hw/rtl/wtf8_to_utf16_decoder_core.sv
// top level of the streaming wtf-8 to utf-16 decoder
`timescale 1ns / 1ps
`include "wtf8_to_utf16_decoder_core_macros.svh"
// Streaming WTF-8 to UTF-16 decoder. Bytes of a string come in one per
// request on the slave side, tlast marking the final byte; UTF-16 code units
// leave one per request on the master side. Bad leads, bad continuations
// and sequences cut short by the end of the string give 0xFFFD, after which
// only the lead byte is dropped and the following bytes are decoded again.
// Overlong forms and encoded surrogates pass through. A byte that only
// extends a held sequence gives no unit. A byte is taken in while the front
// end is idle; the front end then decodes the sequences and errors that the
// byte releases, one per cycle while the queue has room, before it takes the
// next byte. A four-entry command queue lets the front run ahead while the
// output waits; the back end sends one unit a cycle while the output is
// ready and a command queued, a surrogate pair giving high then low units.
module wtf8_to_utf16_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_final
  // output code units
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic [1:0]  m_axis_tuser,   // [0] is_replacement, [1] run_last
  output logic        m_axis_tlast    // string_end
);
  import w2u_pkg::*;

  // front to queue
  logic cmd_push_valid, cmd_push_ready;
  cmd_t cmd_push;
  // queue to back
  logic cmd_pop_valid, cmd_pop_ready;
  cmd_t cmd_pop;

  logic is_repl, run_last, string_end;

  // classify and decode, one sequence per cycle while the queue has room
  w2u_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_final_i  (s_axis_tlast),
    .cmd_valid_o (cmd_push_valid),
    .cmd_ready_i (cmd_push_ready),
    .cmd_o       (cmd_push)
  );

  // decouples decode from output backpressure
  w2u_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_push_valid),
    .push_ready_o (cmd_push_ready),
    .push_data_i  (cmd_push),
    .pop_valid_o  (cmd_pop_valid),
    .pop_ready_i  (cmd_pop_ready),
    .pop_data_o   (cmd_pop)
  );

  // splits pairs and drives the output register
  w2u_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_pop_valid),
    .cmd_ready_o      (cmd_pop_ready),
    .cmd_i            (cmd_pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .code_unit_o      (m_axis_tdata),
    .is_replacement_o (is_repl),
    .run_last_o       (run_last),
    .string_end_o     (string_end)
  );

  assign m_axis_tuser = {run_last, is_repl};
  assign m_axis_tlast = string_end;

  // a taken byte always sends the front into decoding before it takes another byte
  `W2U_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "front took a byte without decoding it")
  // error units carry the replacement value
  `W2U_ASSERT_IMPL(a_repl_value, clk_i, rst_ni, m_axis_tvalid && is_repl, m_axis_tdata == REPL_UNIT, "replacement flag on a non-replacement unit")
  // the end of a string is also the end of its byte's run
  `W2U_ASSERT_IMPL(a_end_is_run_last, clk_i, rst_ni, m_axis_tvalid && string_end, run_last, "string end without run last")

endmodule
